### hdl/malu_pkg.sv
package malu_pkg;

    // Field widths of the stream items, fixed by the instruction format.
    localparam int FIELD_BITS    = 16;
    localparam int OP_BITS       = 4;
    localparam int OFFSET_BITS   = 8;
    localparam int MASK_BITS     = 4;

    // Packed item sizes and the byte-padded stream widths.
    localparam int IN_ITEM_BITS  = 65;
    localparam int IN_DATA_BITS  = 72;
    localparam int OUT_ITEM_BITS = 39;
    localparam int OUT_DATA_BITS = 40;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLR   = 4'd0,
        OP_MOV   = 4'd1,
        OP_ADD   = 4'd2,
        OP_SUB   = 4'd3,
        OP_CMP   = 4'd4,
        OP_INC   = 4'd5,
        OP_DEC   = 4'd6,
        OP_CCODE = 4'd7,
        OP_BGT   = 4'd8,
        OP_BR    = 4'd9
    } op_t;

    // Condition-code layout: N Z V C from the top bit down.
    typedef logic [MASK_BITS-1:0] flags_t;

    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_V = 1;
    localparam int FLAG_C = 0;

    localparam flags_t CC_MASK_NONE = 4'b0000;
    localparam flags_t CC_MASK_C    = 4'b0001;
    localparam flags_t CC_MASK_V    = 4'b0010;
    localparam flags_t CC_MASK_Z    = 4'b0100;
    localparam flags_t CC_MASK_N    = 4'b1000;
    localparam flags_t CC_MASK_ALL  = 4'b1111;

    // Input item; operation, the last field declared, sits in the lowest bits.
    typedef struct packed {
        logic [MASK_BITS-1:0]          cc_mask;
        logic                          cc_set;
        logic [FIELD_BITS-1:0]         pc_now;
        logic signed [OFFSET_BITS-1:0] branch_offset;
        logic [FIELD_BITS-1:0]         dst_word;
        logic [FIELD_BITS-1:0]         src_word;
        logic [OP_BITS-1:0]            operation;
    } in_t;

    // Result item; result_word, the last field declared, sits in the lowest bits.
    typedef struct packed {
        logic                  code_error;
        logic                  flag_c;
        logic                  flag_v;
        logic                  flag_z;
        logic                  flag_n;
        logic                  branch_taken;
        logic [FIELD_BITS-1:0] next_pc;
        logic                  write_back;
        logic [FIELD_BITS-1:0] result_word;
    } out_t;

endpackage

### hdl/malu_exec.sv
module malu_exec #(
    parameter int WORD_BITS = 16
) (
    input  malu_pkg::in_t    item,
    input  malu_pkg::flags_t flags,
    output malu_pkg::out_t   result,
    output malu_pkg::flags_t flags_next
);

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t MAX_POS  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE      = word_t'(1);

    malu_pkg::op_t    op;
    word_t            s_w;
    word_t            d_w;
    word_t            pc_w;
    word_t            off_w;
    word_t            target;
    logic [WORD_BITS:0] sum;
    word_t            sub_a;
    word_t            sub_b;
    logic [WORD_BITS:0] diff;
    word_t            inc_w;
    word_t            dec_w;
    logic             is_cmp;
    logic             mask_ok;
    word_t            res_w;
    word_t            npc_w;
    logic             wb;
    logic             taken;
    logic             err;

    assign op     = malu_pkg::op_t'(item.operation);
    assign s_w    = word_t'(item.src_word);
    assign d_w    = word_t'(item.dst_word);
    assign pc_w   = word_t'(item.pc_now);
    assign off_w  = word_t'(item.branch_offset);
    assign target = pc_w + {off_w[WORD_BITS-2:0], 1'b0};

    assign sum    = {1'b0, d_w} + {1'b0, s_w};

    // One subtractor serves both orders: sub is dst-src, cmp is src-dst.
    assign is_cmp = (op == malu_pkg::OP_CMP);
    assign sub_a  = is_cmp ? s_w : d_w;
    assign sub_b  = is_cmp ? d_w : s_w;
    assign diff   = {1'b0, sub_a} - {1'b0, sub_b};

    assign inc_w  = d_w + ONE;
    assign dec_w  = d_w - ONE;

    assign mask_ok = (item.cc_mask == malu_pkg::CC_MASK_N) ||
                     (item.cc_mask == malu_pkg::CC_MASK_Z) ||
                     (item.cc_mask == malu_pkg::CC_MASK_V) ||
                     (item.cc_mask == malu_pkg::CC_MASK_C) ||
                     (item.cc_mask == malu_pkg::CC_MASK_ALL);

    always_comb
    begin
        flags_next = flags;
        res_w      = '0;
        npc_w      = pc_w;
        wb         = 1'b0;
        taken      = 1'b0;
        err        = 1'b0;
        case (op)
            malu_pkg::OP_CLR:
            begin
                wb         = 1'b1;
                flags_next = malu_pkg::CC_MASK_Z;
            end
            malu_pkg::OP_MOV:
            begin
                res_w                      = s_w;
                wb                         = 1'b1;
                flags_next[malu_pkg::FLAG_N] = s_w[WORD_BITS-1];
                flags_next[malu_pkg::FLAG_Z] = (s_w == '0);
                flags_next[malu_pkg::FLAG_V] = 1'b0;
            end
            malu_pkg::OP_ADD:
            begin
                res_w                      = sum[WORD_BITS-1:0];
                wb                         = 1'b1;
                flags_next[malu_pkg::FLAG_N] = sum[WORD_BITS-1];
                flags_next[malu_pkg::FLAG_Z] = (sum[WORD_BITS-1:0] == '0);
                flags_next[malu_pkg::FLAG_V] = ~(d_w[WORD_BITS-1] ^ s_w[WORD_BITS-1]) &
                                               (d_w[WORD_BITS-1] ^ sum[WORD_BITS-1]);
                flags_next[malu_pkg::FLAG_C] = sum[WORD_BITS];
            end
            malu_pkg::OP_SUB, malu_pkg::OP_CMP:
            begin
                res_w                      = is_cmp ? word_t'(0) : diff[WORD_BITS-1:0];
                wb                         = ~is_cmp;
                flags_next[malu_pkg::FLAG_N] = diff[WORD_BITS-1];
                flags_next[malu_pkg::FLAG_Z] = (diff[WORD_BITS-1:0] == '0);
                // Overflow when the operand signs differ and the result
                // carries the sign of the subtrahend.
                flags_next[malu_pkg::FLAG_V] = (sub_a[WORD_BITS-1] ^ sub_b[WORD_BITS-1]) &
                                               ~(sub_b[WORD_BITS-1] ^ diff[WORD_BITS-1]);
                flags_next[malu_pkg::FLAG_C] = diff[WORD_BITS];
            end
            malu_pkg::OP_INC:
            begin
                res_w                      = inc_w;
                wb                         = 1'b1;
                flags_next[malu_pkg::FLAG_N] = inc_w[WORD_BITS-1];
                flags_next[malu_pkg::FLAG_Z] = (inc_w == '0);
                flags_next[malu_pkg::FLAG_V] = (d_w == MAX_POS);
            end
            malu_pkg::OP_DEC:
            begin
                res_w                      = dec_w;
                wb                         = 1'b1;
                flags_next[malu_pkg::FLAG_N] = dec_w[WORD_BITS-1];
                flags_next[malu_pkg::FLAG_Z] = (dec_w == '0);
                flags_next[malu_pkg::FLAG_V] = (d_w == MOST_NEG);
            end
            malu_pkg::OP_CCODE:
            begin
                if (!item.cc_set && (item.cc_mask == malu_pkg::CC_MASK_NONE))
                begin
                    flags_next = flags;
                end
                else if (mask_ok)
                begin
                    flags_next = item.cc_set ? (flags | item.cc_mask)
                                             : (flags & ~item.cc_mask);
                end
                else
                begin
                    err = 1'b1;
                end
            end
            malu_pkg::OP_BGT:
            begin
                if (!flags[malu_pkg::FLAG_Z] &&
                    (flags[malu_pkg::FLAG_N] == flags[malu_pkg::FLAG_V]))
                begin
                    npc_w = target;
                    taken = 1'b1;
                end
            end
            malu_pkg::OP_BR:
            begin
                npc_w = target;
                taken = 1'b1;
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
    end

    always_comb
    begin
        result.result_word  = malu_pkg::FIELD_BITS'(res_w);
        result.write_back   = wb;
        result.next_pc      = malu_pkg::FIELD_BITS'(npc_w);
        result.branch_taken = taken;
        result.flag_n       = flags_next[malu_pkg::FLAG_N];
        result.flag_z       = flags_next[malu_pkg::FLAG_Z];
        result.flag_v       = flags_next[malu_pkg::FLAG_V];
        result.flag_c       = flags_next[malu_pkg::FLAG_C];
        result.code_error   = err;
    end

endmodule

### hdl/minicomputer_alu_condition_codes.sv
// Condition-code ALU for a small 16-bit minicomputer instruction subset.
// Each request on the s_* stream carries one instruction: the operation,
// the source and destination words, the branch offset, the current PC and
// the condition-code mask. For every request the m_* stream returns exactly
// one result: the destination value and write flag, the next PC and branch
// flag, the N Z V C flags after the instruction and a bad-mask error flag.
// An accepted request goes first into the input register and then into the
// result register, with the execute logic and the flag update between
// them. Throughput is one request per cycle while m_tready stays high;
// the flag register is written as each instruction leaves the input
// register, so the next instruction sees the updated flags directly.
// Reset clears both stage valids and the flags to zero. When the receiver
// holds m_tready low, the result register holds its request, the input
// register fills, and s_tready drops until the result is taken; nothing is
// dropped or repeated. WORD_BITS sets the internal arithmetic width; words
// travel on the ports as 16-bit fields, truncated or zero-extended.
module minicomputer_alu_condition_codes #(
    parameter int WORD_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // operation, src_word, dst_word, branch_offset, pc_now, cc_set, cc_mask
    input  logic [malu_pkg::IN_DATA_BITS-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_word, write_back, next_pc, branch_taken, flag_n, flag_z,
    // flag_v, flag_c, code_error
    output logic [malu_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    // Input stage: holds one request while it executes.
    logic             in_valid_reg;
    malu_pkg::in_t    in_data_reg;

    // Result stage: holds one finished result until the receiver takes it.
    logic             out_valid_reg;
    malu_pkg::out_t   out_data_reg;

    // Architectural condition codes.
    malu_pkg::flags_t flags_reg;
    malu_pkg::flags_t flags_next;

    malu_pkg::out_t   exec_result;
    logic             out_free;
    logic             advance;

    // The result register can load when it is empty or being emptied.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    malu_exec #(
        .WORD_BITS (WORD_BITS)
    ) u_exec (
        .item       (in_data_reg),
        .flags      (flags_reg),
        .result     (exec_result),
        .flags_next (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // Flags commit only when the instruction actually moves on,
            // so a stalled instruction is never applied twice.
            if (advance)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= malu_pkg::in_t'(s_tdata[malu_pkg::IN_ITEM_BITS-1:0]);
        end
        if (advance)
        begin
            out_data_reg <= exec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(malu_pkg::OUT_DATA_BITS - malu_pkg::OUT_ITEM_BITS)'(0),
                       out_data_reg};

endmodule

### hdl/malu_checker.sv
module malu_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [malu_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    malu_pkg::out_t res;

    assign res = malu_pkg::out_t'(m_tdata[malu_pkg::OUT_ITEM_BITS-1:0]);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    // An accepted request is always followed by a valid result on m_tvalid.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result two cycles after an accepted request");

    // An instruction that does not write leaves the result word at zero.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.write_back |-> (res.result_word == '0))
        else $error("result word nonzero without write back");

    // A bad mask comes only from a condition-code instruction.
    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.code_error |-> !res.write_back && !res.branch_taken)
        else $error("code error together with write back or branch");

endmodule

bind minicomputer_alu_condition_codes malu_checker u_malu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/malu_result_checker.sv
// Watches both streams of the condition-code ALU, predicts every result from
// the requests it sees accepted, and compares each accepted result field by
// field with the oldest prediction.
module malu_result_checker
    import malu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,
    output int                       mismatch_count,
    output int                       results_owed
);

    localparam int                    TOP_BIT        = FIELD_BITS - 1;
    localparam logic [FIELD_BITS-1:0] MAX_POS_WORD   = 16'h7fff;
    localparam logic [FIELD_BITS-1:0] MOST_NEG_WORD  = 16'h8000;
    localparam logic [FIELD_BITS-1:0] ONE_WORD       = 16'h0001;

    flags_t cc_flags;
    out_t   pending_results[$];

    // Executes one instruction against the tracked flags and updates them.
    function automatic out_t execute_instr(input in_t ins);
        out_t                  res;
        flags_t                f;
        logic [FIELD_BITS:0]   sum;
        logic [FIELD_BITS-1:0] s;
        logic [FIELD_BITS-1:0] d;
        logic [FIELD_BITS-1:0] r;
        logic [FIELD_BITS-1:0] target;
        logic                  sets_nz;
        s       = ins.src_word;
        d       = ins.dst_word;
        f       = cc_flags;
        r       = '0;
        sets_nz = 1'b0;
        res     = '0;
        res.next_pc = ins.pc_now;
        target = ins.pc_now + {{(FIELD_BITS-OFFSET_BITS-1){ins.branch_offset[OFFSET_BITS-1]}},
                               ins.branch_offset, 1'b0};
        case (ins.operation)
            OP_CLR:
            begin
                res.write_back = 1'b1;
                f = CC_MASK_Z;
            end
            OP_MOV:
            begin
                r = s;
                res.write_back = 1'b1;
                sets_nz = 1'b1;
                f[FLAG_V] = 1'b0;
            end
            OP_ADD:
            begin
                sum = {1'b0, d} + {1'b0, s};
                r = sum[FIELD_BITS-1:0];
                res.write_back = 1'b1;
                sets_nz = 1'b1;
                f[FLAG_V] = ~(d[TOP_BIT] ^ s[TOP_BIT]) & (d[TOP_BIT] ^ r[TOP_BIT]);
                f[FLAG_C] = sum[FIELD_BITS];
            end
            OP_SUB:
            begin
                r = d - s;
                res.write_back = 1'b1;
                sets_nz = 1'b1;
                f[FLAG_V] = (d[TOP_BIT] ^ s[TOP_BIT]) & ~(s[TOP_BIT] ^ r[TOP_BIT]);
                f[FLAG_C] = (d < s);
            end
            OP_CMP:
            begin
                // Compare subtracts the other way round and writes nothing.
                sets_nz = 1'b1;
                r = s - d;
                f[FLAG_V] = (d[TOP_BIT] ^ s[TOP_BIT]) & ~(d[TOP_BIT] ^ r[TOP_BIT]);
                f[FLAG_C] = (s < d);
            end
            OP_INC:
            begin
                r = d + ONE_WORD;
                res.write_back = 1'b1;
                sets_nz = 1'b1;
                f[FLAG_V] = (d == MAX_POS_WORD);
            end
            OP_DEC:
            begin
                r = d - ONE_WORD;
                res.write_back = 1'b1;
                sets_nz = 1'b1;
                f[FLAG_V] = (d == MOST_NEG_WORD);
            end
            OP_CCODE:
            begin
                if (ins.cc_mask == CC_MASK_NONE && !ins.cc_set)
                begin
                    // An empty clear does nothing at all.
                end
                else if (ins.cc_mask == CC_MASK_C || ins.cc_mask == CC_MASK_V ||
                         ins.cc_mask == CC_MASK_Z || ins.cc_mask == CC_MASK_N ||
                         ins.cc_mask == CC_MASK_ALL)
                begin
                    f = ins.cc_set ? (f | ins.cc_mask) : (f & ~ins.cc_mask);
                end
                else
                begin
                    res.code_error = 1'b1;
                end
            end
            OP_BGT:
            begin
                if (!f[FLAG_Z] && (f[FLAG_N] == f[FLAG_V]))
                begin
                    res.next_pc = target;
                    res.branch_taken = 1'b1;
                end
            end
            OP_BR:
            begin
                res.next_pc = target;
                res.branch_taken = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (sets_nz)
        begin
            f[FLAG_N] = r[TOP_BIT];
            f[FLAG_Z] = (r == '0);
        end
        if (res.write_back)
            res.result_word = r;
        res.flag_n = f[FLAG_N];
        res.flag_z = f[FLAG_Z];
        res.flag_v = f[FLAG_V];
        res.flag_c = f[FLAG_C];
        cc_flags = f;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [FIELD_BITS-1:0] got,
                                 input logic [FIELD_BITS-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
    endtask

    task automatic compare_bit(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s is %b, predicted %b", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t got;
        out_t want;
        if (!rst_n)
        begin
            cc_flags = '0;
            pending_results.delete();
            mismatch_count = 0;
            results_owed <= 0;
        end
        else
        begin
            // A request accepted at this edge cannot have its result here, so
            // results are checked before the new prediction is queued.
            if (m_tvalid && m_tready)
            begin
                got = out_t'(m_tdata[OUT_ITEM_BITS-1:0]);
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("result_word", got.result_word, want.result_word);
                    compare_bit("write_back", got.write_back, want.write_back);
                    compare_field("next_pc", got.next_pc, want.next_pc);
                    compare_bit("branch_taken", got.branch_taken, want.branch_taken);
                    compare_bit("flag_n", got.flag_n, want.flag_n);
                    compare_bit("flag_z", got.flag_z, want.flag_z);
                    compare_bit("flag_v", got.flag_v, want.flag_v);
                    compare_bit("flag_c", got.flag_c, want.flag_c);
                    compare_bit("code_error", got.code_error, want.code_error);
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(execute_instr(in_t'(s_tdata[IN_ITEM_BITS-1:0])));
            results_owed <= pending_results.size();
        end
    end

endmodule

### dv/minicomputer_alu_condition_codes_tb.sv
// Top of the testbench for the condition-code ALU. This module only makes
// stimulus and gives the verdict; the checker beside the block watches both
// streams, predicts each result and counts mismatches.
module minicomputer_alu_condition_codes_tb;
    import malu_pkg::*;

    // The limit is far above the slowest correct run, even with the
    // receiver idling two thirds of the time and the long hold-offs.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 375;
    localparam int HOLD_OFF_CYCLES = 80;
    // Two pipeline stages, plus some margin for anything left in flight.
    localparam int DRAIN_CYCLES    = 6;

    // Operation codes that the block must ignore.
    localparam logic [OP_BITS-1:0] OP_SPARE_FIRST = 4'd10;
    localparam logic [OP_BITS-1:0] OP_SPARE_LAST  = 4'd15;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    int mismatch_count;
    int results_owed;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;
    // Long receiver hold-offs asked for so far by the stimulus.
    int hold_off_asked;

    minicomputer_alu_condition_codes uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    malu_result_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Builds one instruction request from its fields.
    function automatic in_t instr(input logic [OP_BITS-1:0] op,
                                  input logic [FIELD_BITS-1:0] src,
                                  input logic [FIELD_BITS-1:0] dst,
                                  input logic [OFFSET_BITS-1:0] offset,
                                  input logic [FIELD_BITS-1:0] pc,
                                  input logic set,
                                  input flags_t mask);
        in_t ins;
        ins.operation     = op;
        ins.src_word      = src;
        ins.dst_word      = dst;
        ins.branch_offset = offset;
        ins.pc_now        = pc;
        ins.cc_set        = set;
        ins.cc_mask       = mask;
        return ins;
    endfunction

    // Words at the sign and carry boundaries, where the flags change.
    function automatic logic [FIELD_BITS-1:0] corner_word();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h7fff;
            3:       return 16'h8000;
            4:       return 16'hfffe;
            default: return 16'hffff;
        endcase
    endfunction

    // A random instruction. Most carry a real operation code, and most
    // condition-code requests carry one of the allowed masks, so that the
    // flags move often and the conditional branch goes both ways.
    function automatic in_t random_instr();
        in_t         ins;
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        ins  = bits[IN_ITEM_BITS-1:0];
        if ($urandom_range(19) == 0)
            ins.operation = OP_BITS'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        else
            ins.operation = OP_BITS'($urandom_range(OP_BR, OP_CLR));
        if ($urandom_range(3) == 0)
            ins.src_word = corner_word();
        if ($urandom_range(3) == 0)
            ins.dst_word = corner_word();
        if ($urandom_range(7) == 0)
            ins.dst_word = ins.src_word;
        if ($urandom_range(7) == 0)
            ins.pc_now = corner_word();
        if ($urandom_range(2) != 0)
        begin
            case ($urandom_range(4))
                0:       ins.cc_mask = CC_MASK_C;
                1:       ins.cc_mask = CC_MASK_V;
                2:       ins.cc_mask = CC_MASK_Z;
                3:       ins.cc_mask = CC_MASK_N;
                default: ins.cc_mask = CC_MASK_ALL;
            endcase
        end
        return ins;
    endfunction

    // Offers one request, after a random number of idle cycles, and returns
    // in the time step of the edge at which it was accepted.
    task automatic send_item(input in_t ins);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_BITS-IN_ITEM_BITS){1'b0}}, ins};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Receiver. It drops m_tready at random, and on request holds it low for
    // a long stretch so that both pipeline stages fill and s_tready falls
    // while the sender keeps offering requests.
    initial
    begin : receiver
        int hold_offs_done;
        hold_offs_done = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_offs_done != hold_off_asked)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_offs_done++;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        int phase;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        send_idle_pct  = 33;
        recv_idle_pct  = 67;
        hold_off_asked = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The flags start from reset at zero, so each request
        // below sees the flags left by the one before it.
        send_item(instr(OP_CLR, 16'h1234, 16'h5678, 8'h05, 16'h0100, 1'b1, CC_MASK_ALL));
        send_item(instr(OP_MOV, 16'h8000, 16'h0000, 8'h00, 16'h0102, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_MOV, 16'h0000, 16'hffff, 8'h00, 16'h0104, 1'b0, CC_MASK_NONE));
        // Signed overflow into the sign bit, then a pure carry to zero.
        send_item(instr(OP_ADD, 16'h0001, 16'h7fff, 8'h00, 16'h0106, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_ADD, 16'h0001, 16'hffff, 8'h00, 16'h0108, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_ADD, 16'h8000, 16'h8000, 8'h00, 16'h010a, 1'b0, CC_MASK_NONE));
        // Borrow, and overflow out of the most negative word.
        send_item(instr(OP_SUB, 16'h0001, 16'h0000, 8'h00, 16'h010c, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_SUB, 16'h0001, 16'h8000, 8'h00, 16'h010e, 1'b0, CC_MASK_NONE));
        // Compare subtracts the destination from the source and writes nothing.
        send_item(instr(OP_CMP, 16'h8000, 16'h0001, 8'h00, 16'h0110, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_CMP, 16'hffff, 16'hffff, 8'h00, 16'h0112, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_INC, 16'h0000, 16'h7fff, 8'h00, 16'h0114, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_INC, 16'h0000, 16'hffff, 8'h00, 16'h0116, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_DEC, 16'h0000, 16'h8000, 8'h00, 16'h0118, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_DEC, 16'hffff, 16'h0000, 8'h00, 16'h011a, 1'b0, CC_MASK_NONE));
        // With Z set the conditional branch falls through.
        send_item(instr(OP_CCODE, 16'h0000, 16'h0000, 8'h00, 16'h011c, 1'b1, CC_MASK_ALL));
        send_item(instr(OP_BGT, 16'h0000, 16'h0000, 8'h10, 16'h011e, 1'b0, CC_MASK_NONE));
        // All flags clear: taken, and the target wraps below zero.
        send_item(instr(OP_CCODE, 16'h0000, 16'h0000, 8'h00, 16'h0120, 1'b0, CC_MASK_ALL));
        send_item(instr(OP_BGT, 16'h0000, 16'h0000, 8'h80, 16'h0000, 1'b0, CC_MASK_NONE));
        // An empty mask with set is refused; an empty clear changes nothing.
        send_item(instr(OP_CCODE, 16'hffff, 16'hffff, 8'h7f, 16'hffff, 1'b1, CC_MASK_NONE));
        send_item(instr(OP_CCODE, 16'h0000, 16'h0000, 8'h00, 16'h0122, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_CCODE, 16'h0000, 16'h0000, 8'h00, 16'h0124, 1'b1,
                        CC_MASK_C | CC_MASK_V));
        // N alone blocks the branch; N and V together let it through.
        send_item(instr(OP_CCODE, 16'h0000, 16'h0000, 8'h00, 16'h0126, 1'b1, CC_MASK_N));
        send_item(instr(OP_BGT, 16'h0000, 16'h0000, 8'h7f, 16'h0128, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_CCODE, 16'h0000, 16'h0000, 8'h00, 16'h012a, 1'b1, CC_MASK_V));
        send_item(instr(OP_BGT, 16'h0000, 16'h0000, 8'h7f, 16'hffff, 1'b0, CC_MASK_NONE));
        send_item(instr(OP_BR, 16'hffff, 16'hffff, 8'hff, 16'h0000, 1'b1, CC_MASK_ALL));
        send_item(instr(OP_SPARE_FIRST, 16'hffff, 16'hffff, 8'h80, 16'h4000, 1'b1,
                        CC_MASK_ALL));
        send_item(instr(OP_SPARE_LAST, 16'h0001, 16'h0001, 8'h01, 16'h8000, 1'b0,
                        CC_MASK_NONE));

        // Random part in three idling patterns. Each phase opens with a long
        // receiver hold-off while requests keep coming.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 67;
                end
                1:
                begin
                    send_idle_pct = 67;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            hold_off_asked++;
            repeat (ITEMS_PER_PHASE) send_item(random_instr());
        end
        s_tvalid <= 1'b0;

        // Wait for every predicted result, then let the pipeline settle.
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
hdl/malu_pkg.sv
hdl/malu_exec.sv
hdl/minicomputer_alu_condition_codes.sv
hdl/malu_checker.sv
dv/malu_result_checker.sv
dv/minicomputer_alu_condition_codes_tb.sv
